// ===== src/palc_pkg.sv =====
// Shared types and constants for the pool allocator with lazy collection.
package palc_pkg;

	// Pool geometry: the field widths of the ports fix the pool at 16 entries
	localparam int POOL_SIZE = 16;
	localparam int IDX_W     = 4;
	localparam int LINK_W    = 5;
	localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_SIZE);

	// Operation codes
	localparam logic [1:0] OP_ALLOC    = 2'd0;
	localparam logic [1:0] OP_RELEASE  = 2'd1;
	localparam logic [1:0] OP_REL_MASK = 2'd2;
	localparam logic [1:0] OP_COLLECT  = 2'd3;

	// One input transfer
	typedef struct packed {
		logic [1:0]       opcode;
		logic [IDX_W-1:0] entry_index;
		logic [7:0]       type_bits;
	} in_item_t;

	// One result transfer
	typedef struct packed {
		logic              ok;
		logic [LINK_W-1:0] granted_entry;
		logic [LINK_W-1:0] pending_count;
		logic [LINK_W-1:0] released_count;
	} result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic step;
		logic finish;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic simple_op;
		logic walk_end;
	} dp_status_t;

endpackage

// ===== src/palc_ctrl.sv =====
// Controller state machine for the pool allocator: sequencing of one operation.
module palc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	output logic                   done,
	output palc_pkg::ctrl_cmd_t    cmd,
	input  palc_pkg::dp_status_t   status
);
	import palc_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic done_q;

	// Command decode
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = start;
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.finish = status.simple_op || status.walk_end;
				cmd.step   = !(status.simple_op || status.walk_end);
				if (cmd.finish) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	assign busy = (state_q == ST_EXEC);
	assign done = done_q;

	// A result strobe only follows the end of an operation
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy && $past(state_q == ST_EXEC))
		else $error("result strobe without a finished operation");

	// An accepted transfer makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transfer did not start an operation");

	// Step and finish never issue together
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.step && cmd.finish))
		else $error("step and finish issued together");

endmodule

// ===== src/palc_dp.sv =====
// Datapath for the pool allocator: lists, alive marks, types, walk and result register.
module palc_dp #(
	parameter logic [7:0] FIRST_ENTRY_TYPE = 8'd1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  palc_pkg::in_item_t     item,
	input  palc_pkg::ctrl_cmd_t    cmd,
	output palc_pkg::dp_status_t   status,
	output palc_pkg::result_t      result
);
	import palc_pkg::*;

	// Pool state
	logic [LINK_W-1:0] link_q [POOL_SIZE];
	logic [7:0]        type_q [POOL_SIZE];
	logic [POOL_SIZE-1:0] alive_q;
	logic [LINK_W-1:0] used_head_q;
	logic [LINK_W-1:0] free_head_q;
	logic [LINK_W-1:0] pending_q;

	// Operation and walk registers
	logic [1:0]        op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [7:0]        tbits_q;
	logic [LINK_W-1:0] cur_q;
	logic [LINK_W-1:0] prev_q;
	logic [LINK_W-1:0] steps_q;
	logic [LINK_W-1:0] hits_q;
	result_t           res_q;
	result_t           res_d;

	logic [IDX_W-1:0]  cur_idx;
	logic [IDX_W-1:0]  free_idx;
	logic [IDX_W-1:0]  rd_addr;
	logic [LINK_W-1:0] rd_link;
	logic              cur_alive;
	logic              mask_hit;
	logic              free_empty;

	// Single link read port: free head on allocate, walk cursor otherwise
	assign cur_idx    = cur_q[IDX_W-1:0];
	assign free_idx   = free_head_q[IDX_W-1:0];
	assign rd_addr    = (op_q == OP_ALLOC) ? free_idx : cur_idx;
	assign rd_link    = link_q[rd_addr];
	assign cur_alive  = alive_q[cur_idx];
	assign mask_hit   = cur_alive && ((type_q[cur_idx] & tbits_q) != 8'd0);
	assign free_empty = (free_head_q >= NIL_LINK);

	// Status to the controller
	assign status.simple_op = (op_q == OP_ALLOC) || (op_q == OP_RELEASE);
	assign status.walk_end  = (cur_q >= NIL_LINK) || (steps_q == LINK_W'(POOL_SIZE)) ||
		((op_q == OP_COLLECT) && (pending_q == '0));

	// Pool state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POOL_SIZE; i++) begin
				link_q[i] <= (i == 0 || i == POOL_SIZE - 1) ? NIL_LINK : LINK_W'(i + 1);
				type_q[i] <= (i == 0) ? FIRST_ENTRY_TYPE : 8'd0;
			end
			alive_q     <= POOL_SIZE'(1);
			used_head_q <= '0;
			free_head_q <= LINK_W'(1);
			pending_q   <= '0;
		end else if (cmd.step) begin
			if (op_q == OP_REL_MASK) begin
				if (mask_hit) begin
					alive_q[cur_idx] <= 1'b0;
					pending_q        <= pending_q + LINK_W'(1);
				end
			end else if (!cur_alive) begin
				// collect: unlink the dead entry and push it on the free head
				if (prev_q >= NIL_LINK) used_head_q <= rd_link;
				else link_q[prev_q[IDX_W-1:0]] <= rd_link;
				link_q[cur_idx] <= free_head_q;
				free_head_q     <= cur_q;
				pending_q       <= pending_q - LINK_W'(1);
			end
		end else if (cmd.finish) begin
			if (op_q == OP_ALLOC) begin
				if (!free_empty) begin
					free_head_q       <= rd_link;
					link_q[free_idx]  <= used_head_q;
					used_head_q       <= free_head_q;
					alive_q[free_idx] <= 1'b1;
					type_q[free_idx]  <= tbits_q;
				end
			end else if (op_q == OP_RELEASE) begin
				if (alive_q[idx_q]) begin
					alive_q[idx_q] <= 1'b0;
					pending_q      <= pending_q + LINK_W'(1);
				end
			end
		end
	end

	// Operation capture and walk cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_ALLOC;
			idx_q   <= '0;
			tbits_q <= '0;
			cur_q   <= NIL_LINK;
			prev_q  <= NIL_LINK;
			steps_q <= '0;
			hits_q  <= '0;
		end else if (cmd.capture) begin
			op_q    <= item.opcode;
			idx_q   <= item.entry_index;
			tbits_q <= item.type_bits;
			cur_q   <= used_head_q;
			prev_q  <= NIL_LINK;
			steps_q <= '0;
			hits_q  <= '0;
		end else if (cmd.step) begin
			cur_q   <= rd_link;
			steps_q <= steps_q + LINK_W'(1);
			if (op_q == OP_REL_MASK) begin
				if (mask_hit) hits_q <= hits_q + LINK_W'(1);
			end else if (cur_alive) begin
				prev_q <= cur_q;
			end
		end
	end

	// Result of the finishing operation
	always_comb begin
		res_d.ok             = 1'b1;
		res_d.granted_entry  = NIL_LINK;
		res_d.pending_count  = pending_q;
		res_d.released_count = '0;
		unique case (op_q)
			OP_ALLOC: begin
				res_d.ok = !free_empty;
				if (!free_empty) res_d.granted_entry = free_head_q;
			end
			OP_RELEASE: begin
				res_d.ok = alive_q[idx_q];
				if (alive_q[idx_q]) begin
					res_d.pending_count  = pending_q + LINK_W'(1);
					res_d.released_count = LINK_W'(1);
				end
			end
			OP_REL_MASK: res_d.released_count = hits_q;
			OP_COLLECT:  res_d.pending_count  = pending_q;
			default:     res_d.ok = 1'b1;
		endcase
	end

	// Result register, loaded on finish
	always_ff @(posedge clk) begin
		if (cmd.finish) res_q <= res_d;
	end

	assign result = res_q;

	// Dead count never exceeds the pool
	a_pending_range: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= LINK_W'(POOL_SIZE))
		else $error("pending count out of range");

	// The two list heads never name the same entry
	a_heads_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(used_head_q != free_head_q) || (used_head_q == NIL_LINK))
		else $error("used and free heads collide");

	// A walk never steps past the pool bound
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> steps_q < LINK_W'(POOL_SIZE))
		else $error("walk past pool bound");

endmodule

// ===== src/pool_allocator_lazy_collect_unit.sv =====
// Top level of the pool allocator with lazy collection.
//
// Command channel: an operation transfer (item) is taken at a rising edge with
// start high and busy low. busy stays high until the operation ends; the next
// transfer may be taken in the same cycle as the previous result strobe.
// Result channel: result is valid for exactly one cycle, marked by done; the
// receiver cannot stall it, so it must take the transfer in that cycle.
// Allocate and release by entry finish without walking a list. Release by
// mask and collect walk the used list one entry per cycle through the single
// link read port, visiting at most the 16 entries of a full list.
// Collect stops early once no dead entries are pending.
// Reset (arst_n low) is asynchronous: entry 0 is alive with FIRST_ENTRY_TYPE
// on the used list, entries 1 to 15 are chained on the free list, nothing is
// pending, and the block is idle with no result pending.
module pool_allocator_lazy_collect_unit #(
	parameter logic [7:0] FIRST_ENTRY_TYPE = 8'd1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  palc_pkg::in_item_t  item,
	output logic                done,
	output palc_pkg::result_t   result
);
	import palc_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Operation sequencer
	palc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.status (status)
	);

	// Pool lists and result register
	palc_dp #(
		.FIRST_ENTRY_TYPE (FIRST_ENTRY_TYPE)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

endmodule

// ===== sim/tb_pool_allocator_lazy_collect_unit.sv =====
// Self-checking testbench for the pool allocator with lazy collection.
`timescale 1ns / 1ps

module tb_pool_allocator_lazy_collect_unit;
	import palc_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1600;
	localparam int DRAIN_CYCLES = 24;

	// Predicts each operation on a private copy of the pool and checks results in order
	class pool_scoreboard;
		logic [LINK_W-1:0] link_next [POOL_SIZE];
		logic              alive     [POOL_SIZE];
		logic [7:0]        kind      [POOL_SIZE];
		int                used_head;
		int                free_head;
		int                dead_pending;
		result_t           expected_results[$];
		int                mismatches;
		int                op_count [4];
		int                refused_allocs;
		int                refused_releases;
		int                mask_hits;
		int                checked;

		function new();
			for (int i = 0; i < POOL_SIZE; i++) begin
				link_next[i] = (i + 1 < POOL_SIZE) ? LINK_W'(i + 1) : NIL_LINK;
				alive[i]     = 1'b0;
				kind[i]      = 8'd0;
			end
			link_next[0] = NIL_LINK;
			alive[0]     = 1'b1;
			kind[0]      = 8'd1;
			used_head    = 0;
			free_head    = 1;
			dead_pending = 0;
			mismatches   = 0;
			foreach (op_count[i]) op_count[i] = 0;
			refused_allocs   = 0;
			refused_releases = 0;
			mask_hits        = 0;
			checked          = 0;
		endfunction

		// Applies one operation to the pool copy and returns the result it must give
		function result_t predict_outcome(in_item_t req);
			result_t r;
			int cur, prev, nxt, steps, hits;
			r.ok             = 1'b1;
			r.granted_entry  = NIL_LINK;
			r.released_count = '0;
			case (req.opcode)
				OP_ALLOC: begin
					if (free_head < POOL_SIZE) begin
						cur = free_head;
						free_head = link_next[cur];
						link_next[cur] = LINK_W'(used_head);
						used_head = cur;
						alive[cur] = 1'b1;
						kind[cur] = req.type_bits;
						r.granted_entry = LINK_W'(cur);
					end else begin
						r.ok = 1'b0;
						refused_allocs++;
					end
				end
				OP_RELEASE: begin
					if (alive[req.entry_index]) begin
						alive[req.entry_index] = 1'b0;
						dead_pending++;
						r.released_count = LINK_W'(1);
					end else begin
						r.ok = 1'b0;
						refused_releases++;
					end
				end
				OP_REL_MASK: begin
					cur = used_head;
					steps = 0;
					hits = 0;
					while (cur < POOL_SIZE && steps < POOL_SIZE) begin
						if (alive[cur] && (kind[cur] & req.type_bits) != 8'd0) begin
							alive[cur] = 1'b0;
							dead_pending++;
							hits++;
						end
						cur = link_next[cur];
						steps++;
					end
					r.released_count = LINK_W'(hits);
					mask_hits += hits;
				end
				default: begin
					// walk the used list, unlinking dead entries onto the free head
					prev = POOL_SIZE;
					cur = used_head;
					steps = 0;
					while (dead_pending != 0 && cur < POOL_SIZE && steps < POOL_SIZE) begin
						nxt = link_next[cur];
						if (!alive[cur]) begin
							if (prev == POOL_SIZE) used_head = nxt;
							else link_next[prev] = LINK_W'(nxt);
							link_next[cur] = LINK_W'(free_head);
							free_head = cur;
							dead_pending--;
						end else begin
							prev = cur;
						end
						cur = nxt;
						steps++;
					end
				end
			endcase
			r.pending_count = LINK_W'(dead_pending);
			return r;
		endfunction

		function void note_request(in_item_t req);
			op_count[req.opcode]++;
			expected_results.push_back(predict_outcome(req));
		endfunction

		function void report_mismatch(string what, result_t exp_r, result_t act_r);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t mismatch (%s): expected ok=%0d grant=%0d pend=%0d rel=%0d, got ok=%0d grant=%0d pend=%0d rel=%0d",
					$time, what, exp_r.ok, exp_r.granted_entry, exp_r.pending_count,
					exp_r.released_count, act_r.ok, act_r.granted_entry,
					act_r.pending_count, act_r.released_count);
		endfunction

		function void check_result(result_t act_r);
			result_t exp_r;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", '0, act_r);
				return;
			end
			exp_r = expected_results.pop_front();
			checked++;
			if (act_r.ok !== exp_r.ok) report_mismatch("ok", exp_r, act_r);
			if (act_r.granted_entry !== exp_r.granted_entry)
				report_mismatch("granted_entry", exp_r, act_r);
			if (act_r.pending_count !== exp_r.pending_count)
				report_mismatch("pending_count", exp_r, act_r);
			if (act_r.released_count !== exp_r.released_count)
				report_mismatch("released_count", exp_r, act_r);
		endfunction

		// Index of a random alive entry, or -1 when none is alive
		function int pick_alive();
			int live[$];
			for (int i = 0; i < POOL_SIZE; i++)
				if (alive[i]) live.push_back(i);
			if (live.size() == 0) return -1;
			return live[$urandom_range(live.size() - 1)];
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	in_item_t item;
	logic     done;
	result_t  result;

	pool_scoreboard sb = new();
	int             cycles = 0;
	int             idle_pct = 0;
	bit             filling = 1'b1;

	pool_allocator_lazy_collect_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Transfer monitors: both sample pre-edge values at the rising edge
	always @(posedge clk) begin
		if (arst_n && start && !busy) sb.note_request(item);
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	// Presents one operation from a falling edge and holds it until the transfer
	task automatic send_op(in_item_t req);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			item  = in_item_t'($urandom);
			@(negedge clk);
		end
		start = 1'b1;
		item  = req;
		do @(posedge clk); while (!(start && !busy));
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		start = 1'b0;
		while (sb.expected_results.size() != 0) @(negedge clk);
	endtask

	function automatic in_item_t make_op(logic [1:0] op, int idx, logic [7:0] bits);
		in_item_t t;
		t.opcode      = op;
		t.entry_index = IDX_W'(idx);
		t.type_bits   = bits;
		return t;
	endfunction

	// Random operation, biased toward filling or draining the pool
	function automatic in_item_t random_op();
		int r, sel;
		int alloc_w, rel_w, mask_w;
		logic [7:0] mask;
		alloc_w = filling ? 45 : 15;
		rel_w   = filling ? 25 : 45;
		mask_w  = 8;
		r = $urandom_range(99);
		if (r < alloc_w)
			return make_op(OP_ALLOC, $urandom_range(15), 8'($urandom));
		if (r < alloc_w + rel_w) begin
			sel = sb.pick_alive();
			if (sel < 0 || $urandom_range(3) == 0) sel = $urandom_range(15);
			return make_op(OP_RELEASE, sel, 8'($urandom));
		end
		if (r < alloc_w + rel_w + mask_w) begin
			mask = ($urandom_range(3) == 0) ? 8'($urandom) : 8'(1 << $urandom_range(7));
			return make_op(OP_REL_MASK, $urandom_range(15), mask);
		end
		return make_op(OP_COLLECT, $urandom_range(15), 8'($urandom));
	endfunction

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty collect, invalid releases, mask with no hit, full pool
		send_op(make_op(OP_COLLECT, 0, 8'h00));
		send_op(make_op(OP_RELEASE, 3, 8'h00));
		send_op(make_op(OP_ALLOC, 0, 8'hFF));
		send_op(make_op(OP_ALLOC, 15, 8'h00));
		send_op(make_op(OP_REL_MASK, 0, 8'h00));
		send_op(make_op(OP_RELEASE, 0, 8'hFF));
		send_op(make_op(OP_RELEASE, 0, 8'h00));
		send_op(make_op(OP_REL_MASK, 15, 8'hFF));
		send_op(make_op(OP_COLLECT, 15, 8'hFF));
		for (int i = 0; i < 15; i++)
			send_op(make_op(OP_ALLOC, i, 8'($urandom_range(1, 255))));
		send_op(make_op(OP_ALLOC, 5, 8'hAA));
		send_op(make_op(OP_REL_MASK, 10, 8'hFF));
		send_op(make_op(OP_RELEASE, 2, 8'h55));
		send_op(make_op(OP_COLLECT, 0, 8'h00));
		send_op(make_op(OP_REL_MASK, 0, 8'hFF));
		wait_all_results();

		// Random phases with different sender idle rates
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case (n / (RANDOM_ITEMS / 4))
				0: idle_pct = 0;
				1: idle_pct = 58;
				2: idle_pct = 0;
				default: idle_pct = 27;
			endcase
			if (n % 40 == 0) filling = ~filling;
			if (n % (RANDOM_ITEMS / 4) == 0 || $urandom_range(199) == 0)
				wait_all_results();
			send_op(random_op());
		end
		start = 1'b0;

		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d allocate, %0d release, %0d mask release, %0d collect operations",
			sb.op_count[OP_ALLOC], sb.op_count[OP_RELEASE], sb.op_count[OP_REL_MASK],
			sb.op_count[OP_COLLECT]);
		$display("%0d results checked: %0d refused allocates, %0d refused releases, %0d mask hits",
			sb.checked, sb.refused_allocs, sb.refused_releases, sb.mask_hits);
		if (sb.mismatches == 0 && sb.expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
